@@ design/mdio_clause22_master_unit_defines.svh @@
// Assertion macros shared by the MDIO clause 22 master modules.
`ifndef MDIO_CLAUSE22_MASTER_UNIT_DEFINES_SVH
`define MDIO_CLAUSE22_MASTER_UNIT_DEFINES_SVH

// Implication checked in the same cycle, quiet while reset is high.
`define MDIO22_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the next cycle, quiet while reset is high.
`define MDIO22_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/mdio22_pkg.sv @@
// Types and constants shared by the MDIO clause 22 master modules.
`default_nettype none

package mdio22_pkg;

   // Operation codes of a request item
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_MREAD = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_SET   = 3'd4;
   localparam logic [2:0] OP_CLEAR = 3'd5;

   // Frame fields
   localparam logic [1:0] FRAME_START = 2'b01;
   localparam logic [1:0] OPC_READ    = 2'b10;
   localparam logic [1:0] OPC_WRITE   = 2'b01;
   localparam logic [1:0] TA_WRITE    = 2'b10;
   localparam logic [1:0] TA_READ     = 2'b00;

   // Bit positions within a 64-bit frame
   localparam logic [5:0] BIT_HEADER   = 6'd32;
   localparam logic [5:0] BIT_DATA     = 6'd48;
   localparam logic [5:0] BIT_LAST     = 6'd63;
   localparam logic [3:0] HDR_TA_FIRST = 4'd14;

   localparam int QUEUE_DEPTH = 2;

   // Class of an item as sorted by the front end
   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_TICK,
      KIND_CMD
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [2:0]  op;
      logic [4:0]  phy_address;
      logic [4:0]  reg_address;
      logic [15:0] value;
      logic        mdio_in;
   } item_type;

   // Head of the queue as seen by the back end
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic        mdc_pulse;
      logic        mdio_out;
      logic        mdio_drive;
      logic        busy_res;
      logic        done_res;
      logic [15:0] read_data;
      logic        rejected;
   } result_type;

endpackage

`default_nettype wire

@@ design/mdio22_if.sv @@
// Request and response channel interfaces of the MDIO clause 22 master.
`default_nettype none

interface mdio22_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [4:0]  phy_address;
   logic [4:0]  reg_address;
   logic [15:0] value;
   logic        mdio_in;

   modport source (output valid, operation, phy_address, reg_address, value, mdio_in,
                   input ready);
   modport sink   (input valid, operation, phy_address, reg_address, value, mdio_in,
                   output ready);
endinterface

interface mdio22_rsp_if;
   logic        valid;
   logic        ready;
   logic        mdc_pulse;
   logic        mdio_out;
   logic        mdio_drive;
   logic        busy_res;
   logic        done_res;
   logic [15:0] read_data;
   logic        rejected;

   modport source (output valid, mdc_pulse, mdio_out, mdio_drive, busy_res, done_res,
                   read_data, rejected, input ready);
   modport sink   (input valid, mdc_pulse, mdio_out, mdio_drive, busy_res, done_res,
                   read_data, rejected, output ready);
endinterface

`default_nettype wire

@@ design/mdio22_front.sv @@
// Front end: accepts request items, classifies them and queues them.
`default_nettype none
`include "mdio_clause22_master_unit_defines.svh"

module mdio22_front (
   input  wire logic            clock,
   input  wire logic            reset,
   mdio22_req_if.sink           req_chan,
   output mdio22_pkg::head_type head,
   input  wire logic            pop
);

   localparam int PTR_W = $clog2(mdio22_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(mdio22_pkg::QUEUE_DEPTH + 1);

   mdio22_pkg::item_type queue_ff [mdio22_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   mdio22_pkg::item_type classified;
   logic                 push;

   // Sort the incoming item
   always_comb begin
      classified.op          = req_chan.operation;
      classified.phy_address = req_chan.phy_address;
      classified.reg_address = req_chan.reg_address;
      classified.value       = req_chan.value;
      classified.mdio_in     = req_chan.mdio_in;
      if (req_chan.operation == mdio22_pkg::OP_TICK) begin
         classified.kind = mdio22_pkg::KIND_TICK;
      end else if (req_chan.operation inside {[mdio22_pkg::OP_READ:mdio22_pkg::OP_CLEAR]})
      begin
         classified.kind = mdio22_pkg::KIND_CMD;
      end else begin
         classified.kind = mdio22_pkg::KIND_NOP;
      end
   end

   assign req_chan.ready = (count_ff != CNT_W'(mdio22_pkg::QUEUE_DEPTH));
   assign push           = req_chan.valid && req_chan.ready;

   // Pointer and fill count bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(mdio22_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(mdio22_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = queue_ff[rd_ptr_ff];

   `MDIO22_ASSERT_SAME(a_pop_nonempty, pop, count_ff != '0, "pop from empty queue")
   `MDIO22_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(mdio22_pkg::QUEUE_DEPTH), "queue overfilled")
   `MDIO22_ASSERT_NEXT(a_count_track, push && !pop, count_ff == $past(count_ff) + CNT_W'(1), "count lost a push")

endmodule

`default_nettype wire

@@ design/mdio22_back.sv @@
// Back end: frame sequencer, shift registers and response register.
`default_nettype none
`include "mdio_clause22_master_unit_defines.svh"

module mdio22_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mdio22_pkg::head_type head,
   output logic                      pop,
   mdio22_rsp_if.source              rsp_chan
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_READ,
      PH_WRITE
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [5:0]             bit_count_ff, bit_count_in;
   logic [15:0]            shift_word_ff, shift_word_in;
   logic [15:0]            captured_ff, captured_in;
   logic [2:0]             pend_op_ff, pend_op_in;
   logic [4:0]             held_phy_ff, held_phy_in;
   logic [4:0]             held_reg_ff, held_reg_in;
   logic [15:0]            held_value_ff, held_value_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   mdio22_pkg::result_type rsp_ff, rsp_in;

   logic                   wr;
   logic [15:0]            header;
   logic [3:0]             nib;
   mdio22_pkg::item_type   it;

   assign it  = head.item;
   assign pop = head.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign wr  = (phase_ff == PH_WRITE);
   assign nib = bit_count_ff[3:0];
   assign header = {mdio22_pkg::FRAME_START,
                    wr ? mdio22_pkg::OPC_WRITE : mdio22_pkg::OPC_READ,
                    held_phy_ff, held_reg_ff,
                    wr ? mdio22_pkg::TA_WRITE : mdio22_pkg::TA_READ};

   // Execute the item at the queue head
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_word_in = shift_word_ff;
      captured_in   = captured_ff;
      pend_op_in    = pend_op_ff;
      held_phy_in   = held_phy_ff;
      held_reg_in   = held_reg_ff;
      held_value_in = held_value_ff;
      rsp_in        = '0;
      case (it.kind)
         mdio22_pkg::KIND_CMD: begin
            if (phase_ff != PH_IDLE) begin
               rsp_in.rejected = 1'b1;
            end else begin
               pend_op_in    = it.op;
               held_phy_in   = it.phy_address;
               held_reg_in   = it.reg_address;
               held_value_in = it.value;
               phase_in      = (it.op == mdio22_pkg::OP_WRITE) ? PH_WRITE : PH_READ;
               bit_count_in  = '0;
               captured_in   = '0;
               shift_word_in = (it.op == mdio22_pkg::OP_WRITE) ? it.value : '0;
            end
         end
         mdio22_pkg::KIND_TICK: begin
            if (phase_ff != PH_IDLE) begin
               rsp_in.mdc_pulse = 1'b1;
               if (bit_count_ff < mdio22_pkg::BIT_HEADER) begin
                  // preamble
                  rsp_in.mdio_drive = 1'b1;
                  rsp_in.mdio_out   = 1'b1;
               end else if (bit_count_ff < mdio22_pkg::BIT_DATA) begin
                  // start, opcode, addresses, turnaround
                  rsp_in.mdio_drive = wr || (nib < mdio22_pkg::HDR_TA_FIRST);
                  rsp_in.mdio_out   = rsp_in.mdio_drive && header[~nib];
               end else if (wr) begin
                  rsp_in.mdio_drive = 1'b1;
                  rsp_in.mdio_out   = shift_word_ff[~nib];
               end else begin
                  captured_in = {captured_ff[14:0], it.mdio_in};
               end
               if (bit_count_ff == mdio22_pkg::BIT_LAST) begin
                  bit_count_in = '0;
                  if (!wr && (pend_op_ff == mdio22_pkg::OP_SET ||
                              pend_op_ff == mdio22_pkg::OP_CLEAR)) begin
                     // read half of read-modify-write done
                     shift_word_in = (pend_op_ff == mdio22_pkg::OP_SET)
                                     ? (captured_in | held_value_ff)
                                     : (captured_in & ~held_value_ff);
                     phase_in = PH_WRITE;
                  end else begin
                     rsp_in.done_res = 1'b1;
                     phase_in        = PH_IDLE;
                     if (pend_op_ff == mdio22_pkg::OP_MREAD) begin
                        rsp_in.read_data = captured_in & held_value_ff;
                     end else if (pend_op_ff == mdio22_pkg::OP_READ ||
                                  pend_op_ff == mdio22_pkg::OP_SET ||
                                  pend_op_ff == mdio22_pkg::OP_CLEAR) begin
                        rsp_in.read_data = captured_in;
                     end
                  end
               end else begin
                  bit_count_in = bit_count_ff + 6'd1;
               end
            end
         end
         default: ;
      endcase
      rsp_in.busy_res = (phase_in != PH_IDLE);
      rsp_valid_in = pop ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   // Sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_word_ff <= '0;
         captured_ff   <= '0;
         pend_op_ff    <= '0;
         held_phy_ff   <= '0;
         held_reg_ff   <= '0;
         held_value_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_word_ff <= shift_word_in;
            captured_ff   <= captured_in;
            pend_op_ff    <= pend_op_in;
            held_phy_ff   <= held_phy_in;
            held_reg_ff   <= held_reg_in;
            held_value_ff <= held_value_in;
         end
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mdc_pulse  = rsp_ff.mdc_pulse;
   assign rsp_chan.mdio_out   = rsp_ff.mdio_out;
   assign rsp_chan.mdio_drive = rsp_ff.mdio_drive;
   assign rsp_chan.busy_res   = rsp_ff.busy_res;
   assign rsp_chan.done_res   = rsp_ff.done_res;
   assign rsp_chan.read_data  = rsp_ff.read_data;
   assign rsp_chan.rejected   = rsp_ff.rejected;

   `MDIO22_ASSERT_SAME(a_done_pulses, rsp_valid_ff && rsp_ff.done_res,
      rsp_ff.mdc_pulse, "done without MDC pulse")
   `MDIO22_ASSERT_SAME(a_idle_count, phase_ff == PH_IDLE, bit_count_ff == '0,
      "bit count set while idle")
   `MDIO22_ASSERT_SAME(a_stall_no_pop, rsp_valid_ff && !rsp_chan.ready, !pop,
      "response overwritten")

endmodule

`default_nettype wire

@@ design/mdio_clause22_master_unit.sv @@
// Top level of the MDIO clause 22 management master.
//
//   channel   role     content
//   req_chan  in       operation, phy/reg address, value, sampled mdio_in
//   rsp_chan  out      MDC pulse, MDIO level and drive, busy, done, read data, rejected
//
// One item per cycle sustained while rsp_chan is ready; each item yields one response.
// An item passes through the two-entry queue and then the response register.
// The frame sequencer advances one bit time per tick item in a single step.
// Synchronous reset empties the queue and returns the sequencer to idle.
// A stalled response holds the sequencer; the queue keeps taking items until full.
`default_nettype none

module mdio_clause22_master_unit (
   input wire logic       clock,
   input wire logic       reset,
   mdio22_req_if.sink     req_chan,
   mdio22_rsp_if.source   rsp_chan
);

   mdio22_pkg::head_type head;
   logic                 pop;

   mdio22_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   mdio22_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
